// File: design/uartbuf_pkg.sv
package uartbuf_pkg;

  typedef enum logic [1:0] {
    REQ_PUT  = 2'd0,
    REQ_RX   = 2'd1,
    REQ_DONE = 2'd2,
    REQ_READ = 2'd3
  } req_type_t;

  localparam logic [7:0] CH_LF = 8'h0A;
  localparam logic [7:0] CH_CR = 8'h0D;

  typedef struct packed {
    req_type_t  req_type;
    logic [7:0] data_byte;
    logic [3:0] line_index;
  } req_t;

  typedef struct packed {
    logic       accepted;
    logic       tx_start;
    logic [7:0] tx_byte;
    logic       line_complete;
    logic [4:0] line_length;
    logic [7:0] read_data;
    logic       fifo_full;
    logic       tx_busy;
  } res_t;

endpackage

// File: design/uart_tx_fifo_rx_line_buffer.sv
// a request's result is registered in the read stage and then in the result register
// throughput: one request a cycle while results are taken; the memory read stage
//   and the result register each hold one request
// reset: synchronous, clears pointers, counts, transmitter state and the line
//   store's valid bits at once; no clearing pass
module uart_tx_fifo_rx_line_buffer #(
  parameter int TX_DEPTH = 32,
  parameter int RX_DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_ready,
  input  uartbuf_pkg::req_t  req,
  output logic               res_valid,
  input  logic               res_ready,
  output uartbuf_pkg::res_t  res
);
  import uartbuf_pkg::*;

  localparam int TXAW   = $clog2(TX_DEPTH);
  localparam int CNT_W  = $clog2(TX_DEPTH + 1);
  localparam int RXAW   = $clog2(RX_DEPTH);
  localparam int FILL_W = $clog2(RX_DEPTH + 1);
  localparam logic [TXAW-1:0]   TX_LAST = TXAW'(TX_DEPTH - 1);
  localparam logic [CNT_W-1:0]  TX_FULL = CNT_W'(TX_DEPTH);
  localparam logic [FILL_W-1:0] RX_FULL = FILL_W'(RX_DEPTH);
  localparam logic [RXAW+3:0]   RX_LIM  = (RXAW + 4)'(RX_DEPTH);

  // transmit queue and line store
  logic [7:0] tx_mem [TX_DEPTH];
  logic [7:0] rx_mem [RX_DEPTH];
  logic [7:0] tx_rd;
  logic [7:0] rx_rd;
  logic [RX_DEPTH-1:0] rx_vld;

  logic [TXAW-1:0]   tx_head, tx_head_next;
  logic [TXAW-1:0]   tx_tail, tx_tail_next;
  logic [CNT_W-1:0]  tx_count, tx_count_next;
  logic              tx_active, tx_active_next;
  logic [FILL_W-1:0] rx_fill, rx_fill_next;
  logic [FILL_W-1:0] last_length, last_length_next;
  logic              last_cr, last_cr_next;

  // read stage
  logic       s1_valid;
  res_t       s1_res;
  logic       s1_from_mem;
  logic       s1_rd_ok;
  logic       s1_move;
  logic       req_fire;
  res_t       res_next;

  logic       tx_we, tx_re, rx_we;
  logic [RXAW-1:0] rx_waddr;
  logic [RXAW+3:0] idx_ext;
  logic [RXAW-1:0] rx_raddr;
  logic       idx_in_range;
  logic       acc, start, done, from_mem, rd_ok;
  logic [7:0] direct_byte;
  logic [FILL_W+4:0] len_ext;

  assign s1_move   = s1_valid && (!res_valid || res_ready);
  assign req_ready = !s1_valid || s1_move;
  assign req_fire  = req_valid && req_ready;

  assign rx_waddr     = rx_fill[RXAW-1:0];
  assign idx_ext      = {{RXAW{1'b0}}, req.line_index};
  assign rx_raddr     = idx_ext[RXAW-1:0];
  assign idx_in_range = idx_ext < RX_LIM;

  always_comb begin
    tx_head_next     = tx_head;
    tx_tail_next     = tx_tail;
    tx_count_next    = tx_count;
    tx_active_next   = tx_active;
    rx_fill_next     = rx_fill;
    last_length_next = last_length;
    last_cr_next     = last_cr;
    tx_we       = 1'b0;
    tx_re       = 1'b0;
    rx_we       = 1'b0;
    acc         = 1'b0;
    start       = 1'b0;
    done        = 1'b0;
    from_mem    = 1'b0;
    rd_ok       = 1'b0;
    direct_byte = 8'd0;
    if (req_fire) begin
      case (req.req_type)
        REQ_PUT: begin
          if (tx_count != TX_FULL) begin
            acc = 1'b1;
            if (!tx_active) begin
              tx_active_next = 1'b1;
              start          = 1'b1;
              direct_byte    = req.data_byte;
            end else begin
              tx_we         = 1'b1;
              tx_tail_next  = (tx_tail == TX_LAST) ? '0 : tx_tail + 1'b1;
              tx_count_next = tx_count + 1'b1;
            end
          end
        end
        REQ_RX: begin
          if (rx_fill != RX_FULL) begin
            rx_we        = 1'b1;
            last_cr_next = (req.data_byte == CH_CR);
            // cr must be the previous byte of this same line
            if (req.data_byte == CH_LF && rx_fill != '0 && last_cr) begin
              done             = 1'b1;
              last_length_next = rx_fill + 1'b1;
              rx_fill_next     = '0;
            end else begin
              rx_fill_next = rx_fill + 1'b1;
            end
          end else begin
            rx_fill_next = '0;
          end
        end
        REQ_DONE: begin
          if (tx_count != '0) begin
            start         = 1'b1;
            from_mem      = 1'b1;
            tx_re         = 1'b1;
            tx_head_next  = (tx_head == TX_LAST) ? '0 : tx_head + 1'b1;
            tx_count_next = tx_count - 1'b1;
          end else begin
            tx_active_next = 1'b0;
          end
        end
        REQ_READ: begin
          rd_ok = idx_in_range && rx_vld[rx_raddr];
        end
        default: begin
        end
      endcase
    end
  end

  assign len_ext = {5'd0, last_length_next};

  always_ff @(posedge clk) begin
    if (tx_we) begin
      tx_mem[tx_tail] <= req.data_byte;
    end
    if (tx_re) begin
      tx_rd <= tx_mem[tx_head];
    end
  end

  always_ff @(posedge clk) begin
    if (rx_we) begin
      rx_mem[rx_waddr] <= req.data_byte;
    end
    if (req_fire && req.req_type == REQ_READ && idx_in_range) begin
      rx_rd <= rx_mem[rx_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tx_head     <= '0;
      tx_tail     <= '0;
      tx_count    <= '0;
      tx_active   <= 1'b0;
      rx_fill     <= '0;
      last_length <= '0;
      last_cr     <= 1'b0;
      rx_vld      <= '0;
    end else begin
      tx_head     <= tx_head_next;
      tx_tail     <= tx_tail_next;
      tx_count    <= tx_count_next;
      tx_active   <= tx_active_next;
      rx_fill     <= rx_fill_next;
      last_length <= last_length_next;
      last_cr     <= last_cr_next;
      if (rx_we) begin
        rx_vld[rx_waddr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req_fire) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req_fire) begin
      s1_res.accepted      <= acc;
      s1_res.tx_start      <= start;
      s1_res.tx_byte       <= direct_byte;
      s1_res.line_complete <= done;
      s1_res.line_length   <= len_ext[4:0];
      s1_res.read_data     <= 8'd0;
      s1_res.fifo_full     <= (tx_count_next == TX_FULL);
      s1_res.tx_busy       <= tx_active_next;
      s1_from_mem          <= from_mem;
      s1_rd_ok             <= rd_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (s1_move) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  // memory read data is held until the next request, so a stalled stage still sees it
  always_comb begin
    res_next           = s1_res;
    res_next.tx_byte   = s1_from_mem ? tx_rd : s1_res.tx_byte;
    res_next.read_data = s1_rd_ok ? rx_rd : 8'd0;
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      res <= res_next;
    end
  end

endmodule
